// ===== rtl/ell_pkg.sv =====
// ----------------------------------------------------------------------------
// Expression lexer package
// Token, error and scan mode codes, character constants and keyword tables
// shared by the lexer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ell_pkg;

    typedef enum logic [4:0] {
        KIND_EOF     = 5'd0,
        KIND_IDENT   = 5'd1,
        KIND_NUMBER  = 5'd2,
        KIND_STRING  = 5'd3,
        KIND_TRUE    = 5'd4,
        KIND_FALSE   = 5'd5,
        KIND_NIL     = 5'd6,
        KIND_PRINT   = 5'd7,
        KIND_PLUS    = 5'd8,
        KIND_MINUS   = 5'd9,
        KIND_STAR    = 5'd10,
        KIND_SLASH   = 5'd11,
        KIND_LPAREN  = 5'd12,
        KIND_RPAREN  = 5'd13,
        KIND_LT      = 5'd14,
        KIND_LE      = 5'd15,
        KIND_GT      = 5'd16,
        KIND_GE      = 5'd17,
        KIND_ASSIGN  = 5'd18,
        KIND_EQ      = 5'd19,
        KIND_BANG    = 5'd20,
        KIND_NE      = 5'd21,
        KIND_LBRACE  = 5'd22,
        KIND_RBRACE  = 5'd23,
        KIND_UNKNOWN = 5'd24
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_UNKNOWN = 2'd1,
        ERR_UNTERM  = 2'd2,
        ERR_DECIMAL = 2'd3
    } err_t;

    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_IDENT   = 6'b000010,
        MODE_NUMBER  = 6'b000100,
        MODE_STRING  = 6'b001000,
        MODE_COMMENT = 6'b010000,
        MODE_OPER    = 6'b100000
    } scan_mode_t;

    typedef enum logic [1:0] {
        POP_LT     = 2'd0,
        POP_GT     = 2'd1,
        POP_ASSIGN = 2'd2,
        POP_BANG   = 2'd3
    } pend_op_t;

    typedef enum logic [1:0] {
        KW_TRUE  = 2'd0,
        KW_FALSE = 2'd1,
        KW_NIL   = 2'd2,
        KW_PRINT = 2'd3
    } kw_t;

    localparam int KW_COUNT = 4;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] length;
        err_t        err;
        logic        last;
    } token_t;

    typedef struct packed {
        logic       load;
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } step_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {8'h20, [8'h09:8'h0D]});
    endfunction

    function automatic logic [7:0] kw_char(input kw_t k, input logic [2:0] idx);
        logic [39:0] word;
        logic [39:0] shifted;
        case (k)
            KW_TRUE:  word = {"true", 8'h00};
            KW_FALSE: word = "false";
            KW_NIL:   word = {"nil", 16'h0000};
            KW_PRINT: word = "print";
            default:  word = '0;
        endcase
        shifted = word << {idx, 3'b000};
        return shifted[39:32];
    endfunction

    function automatic logic [2:0] kw_len(input kw_t k);
        case (k)
            KW_TRUE:  return 3'd4;
            KW_FALSE: return 3'd5;
            KW_NIL:   return 3'd3;
            KW_PRINT: return 3'd5;
            default:  return 3'd0;
        endcase
    endfunction

    function automatic kind_t kw_kind(input kw_t k);
        case (k)
            KW_TRUE:  return KIND_TRUE;
            KW_FALSE: return KIND_FALSE;
            KW_NIL:   return KIND_NIL;
            KW_PRINT: return KIND_PRINT;
            default:  return KIND_IDENT;
        endcase
    endfunction

    function automatic kind_t op_kind(input pend_op_t op, input logic two);
        case (op)
            POP_LT:     return two ? KIND_LE : KIND_LT;
            POP_GT:     return two ? KIND_GE : KIND_GT;
            POP_ASSIGN: return two ? KIND_EQ : KIND_ASSIGN;
            POP_BANG:   return two ? KIND_NE : KIND_BANG;
            default:    return KIND_UNKNOWN;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ell_text_if.sv =====
// ----------------------------------------------------------------------------
// Text channel
// Carries one source byte or an end-of-text mark per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ell_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== rtl/ell_token_if.sv =====
// ----------------------------------------------------------------------------
// Token channel
// Carries one token with its kind, position, length and error per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ell_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [1:0]  error_kind;
    logic        last_of_run;

    modport source (
        output valid, output token_kind, output token_start, output token_length,
        output error_kind, output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input token_start, input token_length,
        input error_kind, input last_of_run, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/ell_core.sv =====
// ----------------------------------------------------------------------------
// Lexer scan core
// Registers the incoming beat, then runs one scan step on it against the
// lexer state and hands up to two tokens to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ell_core #(
    parameter int PB = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [7:0]     in_byte,
    input  logic           in_eot,
    output logic           in_ready,
    input  logic           q_free,
    output ell_pkg::step_t step
);

    logic                    vld_reg;
    logic [7:0]              byte_reg;
    logic                    eot_reg;
    logic                    fire;

    ell_pkg::scan_mode_t     mode_reg, mode_next;
    ell_pkg::pend_op_t       pop_reg, pop_next;
    logic [ell_pkg::KW_COUNT-1:0] cand_reg, cand_next;
    logic                    dec_reg, dec_next;
    logic [PB-1:0]           begin_reg, begin_next;
    logic [PB-1:0]           count_reg, count_next;
    logic [PB-1:0]           pos_reg, pos_next;

    ell_pkg::scan_mode_t     idl_mode;
    ell_pkg::pend_op_t       idl_pop;
    logic [ell_pkg::KW_COUNT-1:0] idl_cand;
    logic                    idl_dec;
    logic [PB-1:0]           idl_begin;
    logic [PB-1:0]           idl_count;
    logic                    idl_emit;
    ell_pkg::token_t         idl_res;

    logic [ell_pkg::KW_COUNT-1:0] cand_upd;
    logic [PB-1:0]           count_inc;
    ell_pkg::kind_t          ident_kind;
    logic                    use_idle;
    logic                    pre_v, post_v;
    ell_pkg::token_t         pre_r, post_r;

    assign fire     = vld_reg && q_free;
    assign in_ready = !vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
            eot_reg  <= in_eot;
        end
    end

    assign count_inc = (count_reg == {PB{1'b1}}) ? count_reg : count_reg + PB'(1);

    always_comb
    begin
        ident_kind = ell_pkg::KIND_IDENT;
        for (int k = 0; k < ell_pkg::KW_COUNT; k++)
        begin
            if (cand_reg[k] && count_reg == PB'(ell_pkg::kw_len(ell_pkg::kw_t'(k))))
            begin
                ident_kind = ell_pkg::kw_kind(ell_pkg::kw_t'(k));
            end
            cand_upd[k] = cand_reg[k]
                && (count_reg < PB'(ell_pkg::kw_len(ell_pkg::kw_t'(k))))
                && (ell_pkg::kw_char(ell_pkg::kw_t'(k), count_reg[2:0]) == byte_reg);
        end
    end

    // Scan of the current byte from the state between tokens.
    always_comb
    begin
        idl_mode      = ell_pkg::MODE_IDLE;
        idl_pop       = pop_reg;
        idl_cand      = cand_reg;
        idl_dec       = dec_reg;
        idl_begin     = begin_reg;
        idl_count     = count_reg;
        idl_emit      = 1'b0;
        idl_res.kind  = ell_pkg::KIND_UNKNOWN;
        idl_res.start = 16'(pos_reg);
        idl_res.length = 16'd1;
        idl_res.err   = ell_pkg::ERR_NONE;
        idl_res.last  = 1'b0;
        if (ell_pkg::is_space(byte_reg))
        begin
            idl_mode = ell_pkg::MODE_IDLE;
        end
        else if (ell_pkg::is_alpha(byte_reg))
        begin
            idl_mode  = ell_pkg::MODE_IDENT;
            idl_begin = pos_reg;
            idl_count = PB'(1);
            for (int k = 0; k < ell_pkg::KW_COUNT; k++)
            begin
                idl_cand[k] = (ell_pkg::kw_char(ell_pkg::kw_t'(k), 3'd0) == byte_reg);
            end
        end
        else if (ell_pkg::is_digit(byte_reg))
        begin
            idl_mode  = ell_pkg::MODE_NUMBER;
            idl_begin = pos_reg;
            idl_count = PB'(1);
            idl_dec   = 1'b0;
        end
        else
        begin
            case (byte_reg)
                ell_pkg::CH_QUOTE:
                begin
                    idl_mode  = ell_pkg::MODE_STRING;
                    idl_begin = pos_reg + PB'(1);
                    idl_count = '0;
                end
                ell_pkg::CH_HASH:
                begin
                    idl_mode = ell_pkg::MODE_COMMENT;
                end
                ell_pkg::CH_LT, ell_pkg::CH_GT, ell_pkg::CH_EQUAL, ell_pkg::CH_BANG:
                begin
                    idl_mode  = ell_pkg::MODE_OPER;
                    idl_begin = pos_reg;
                    case (byte_reg)
                        ell_pkg::CH_LT:    idl_pop = ell_pkg::POP_LT;
                        ell_pkg::CH_GT:    idl_pop = ell_pkg::POP_GT;
                        ell_pkg::CH_EQUAL: idl_pop = ell_pkg::POP_ASSIGN;
                        default:           idl_pop = ell_pkg::POP_BANG;
                    endcase
                end
                ell_pkg::CH_PLUS:   begin idl_emit = 1'b1; idl_res.kind = ell_pkg::KIND_PLUS;   end
                ell_pkg::CH_MINUS:  begin idl_emit = 1'b1; idl_res.kind = ell_pkg::KIND_MINUS;  end
                ell_pkg::CH_STAR:   begin idl_emit = 1'b1; idl_res.kind = ell_pkg::KIND_STAR;   end
                ell_pkg::CH_SLASH:  begin idl_emit = 1'b1; idl_res.kind = ell_pkg::KIND_SLASH;  end
                ell_pkg::CH_LPAREN: begin idl_emit = 1'b1; idl_res.kind = ell_pkg::KIND_LPAREN; end
                ell_pkg::CH_RPAREN: begin idl_emit = 1'b1; idl_res.kind = ell_pkg::KIND_RPAREN; end
                ell_pkg::CH_LBRACE: begin idl_emit = 1'b1; idl_res.kind = ell_pkg::KIND_LBRACE; end
                ell_pkg::CH_RBRACE: begin idl_emit = 1'b1; idl_res.kind = ell_pkg::KIND_RBRACE; end
                default:
                begin
                    idl_emit       = 1'b1;
                    idl_res.kind   = ell_pkg::KIND_UNKNOWN;
                    idl_res.length = 16'd0;
                    idl_res.err    = ell_pkg::ERR_UNKNOWN;
                end
            endcase
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        pop_next   = pop_reg;
        cand_next  = cand_reg;
        dec_next   = dec_reg;
        begin_next = begin_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        use_idle   = 1'b0;
        pre_v      = 1'b0;
        post_v     = 1'b0;
        pre_r.kind   = ell_pkg::KIND_UNKNOWN;
        pre_r.start  = 16'(begin_reg);
        pre_r.length = 16'(count_reg);
        pre_r.err    = ell_pkg::ERR_NONE;
        pre_r.last   = 1'b0;
        post_r       = idl_res;
        if (eot_reg)
        begin
            case (mode_reg)
                ell_pkg::MODE_IDENT:
                begin
                    pre_v      = 1'b1;
                    pre_r.kind = ident_kind;
                end
                ell_pkg::MODE_NUMBER:
                begin
                    pre_v      = 1'b1;
                    pre_r.kind = ell_pkg::KIND_NUMBER;
                end
                ell_pkg::MODE_STRING:
                begin
                    pre_v      = 1'b1;
                    pre_r.kind = ell_pkg::KIND_UNKNOWN;
                    pre_r.err  = ell_pkg::ERR_UNTERM;
                end
                ell_pkg::MODE_OPER:
                begin
                    pre_v        = 1'b1;
                    pre_r.kind   = ell_pkg::op_kind(pop_reg, 1'b0);
                    pre_r.length = 16'd1;
                end
                default:
                begin
                    pre_v = 1'b0;
                end
            endcase
            post_v        = 1'b1;
            post_r.kind   = ell_pkg::KIND_EOF;
            post_r.start  = 16'(pos_reg);
            post_r.length = 16'd0;
            post_r.err    = ell_pkg::ERR_NONE;
            post_r.last   = 1'b0;
            mode_next  = ell_pkg::MODE_IDLE;
            pop_next   = ell_pkg::POP_LT;
            cand_next  = '0;
            dec_next   = 1'b0;
            begin_next = '0;
            count_next = '0;
            pos_next   = '0;
        end
        else
        begin
            pos_next = pos_reg + PB'(1);
            case (mode_reg)
                ell_pkg::MODE_IDENT:
                begin
                    if (ell_pkg::is_alpha(byte_reg) || ell_pkg::is_digit(byte_reg))
                    begin
                        cand_next  = cand_upd;
                        count_next = count_inc;
                    end
                    else
                    begin
                        pre_v      = 1'b1;
                        pre_r.kind = ident_kind;
                        use_idle   = 1'b1;
                    end
                end
                ell_pkg::MODE_NUMBER:
                begin
                    if (ell_pkg::is_digit(byte_reg))
                    begin
                        count_next = count_inc;
                    end
                    else if (byte_reg == ell_pkg::CH_DOT)
                    begin
                        if (dec_reg)
                        begin
                            pre_v        = 1'b1;
                            pre_r.kind   = ell_pkg::KIND_UNKNOWN;
                            pre_r.start  = 16'(pos_reg);
                            pre_r.length = 16'd1;
                            pre_r.err    = ell_pkg::ERR_DECIMAL;
                            use_idle     = 1'b1;
                        end
                        else
                        begin
                            dec_next   = 1'b1;
                            count_next = count_inc;
                        end
                    end
                    else
                    begin
                        pre_v      = 1'b1;
                        pre_r.kind = ell_pkg::KIND_NUMBER;
                        use_idle   = 1'b1;
                    end
                end
                ell_pkg::MODE_STRING:
                begin
                    if (byte_reg == ell_pkg::CH_QUOTE)
                    begin
                        pre_v      = 1'b1;
                        pre_r.kind = ell_pkg::KIND_STRING;
                        mode_next  = ell_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                ell_pkg::MODE_COMMENT:
                begin
                    if (byte_reg == ell_pkg::CH_NEWLINE)
                    begin
                        mode_next = ell_pkg::MODE_IDLE;
                    end
                end
                ell_pkg::MODE_OPER:
                begin
                    pre_v = 1'b1;
                    if (byte_reg == ell_pkg::CH_EQUAL)
                    begin
                        pre_r.kind   = ell_pkg::op_kind(pop_reg, 1'b1);
                        pre_r.length = 16'd2;
                        mode_next    = ell_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        pre_r.kind   = ell_pkg::op_kind(pop_reg, 1'b0);
                        pre_r.length = 16'd1;
                        use_idle     = 1'b1;
                    end
                end
                default:
                begin
                    use_idle = 1'b1;
                end
            endcase
            if (use_idle)
            begin
                mode_next  = idl_mode;
                pop_next   = idl_pop;
                cand_next  = idl_cand;
                dec_next   = idl_dec;
                begin_next = idl_begin;
                count_next = idl_count;
                post_v     = idl_emit;
            end
        end
    end

    always_comb
    begin
        step.load  = fire;
        step.count = {1'b0, pre_v} + {1'b0, post_v};
        step.first  = pre_v ? pre_r : post_r;
        step.second = post_r;
        step.first.last  = !(pre_v && post_v);
        step.second.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ell_pkg::MODE_IDLE;
            pop_reg   <= ell_pkg::POP_LT;
            cand_reg  <= '0;
            dec_reg   <= 1'b0;
            begin_reg <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            pop_reg   <= pop_next;
            cand_reg  <= cand_next;
            dec_reg   <= dec_next;
            begin_reg <= begin_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_eot_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && eot_reg |=> pos_reg == '0 && mode_reg == ell_pkg::MODE_IDLE)
        else $error("position or mode not cleared after end of text");
    a_eot_emits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && eot_reg |-> step.count != 2'd0)
        else $error("end of text produced no token");
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !eot_reg && mode_reg == ell_pkg::MODE_STRING
        && byte_reg != ell_pkg::CH_QUOTE |=> count_reg >= $past(count_reg))
        else $error("string length went backwards");
`endif

endmodule

`default_nettype wire

// ===== rtl/ell_outq.sv =====
// ----------------------------------------------------------------------------
// Lexer result queue
// Two-entry token buffer that drains the tokens of one scan step one beat
// at a time onto the token channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ell_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  ell_pkg::step_t  step,
    output logic            q_free,
    ell_token_if.source     tokens
);

    logic [1:0]      cnt_reg, cnt_next;
    ell_pkg::token_t slot0_reg, slot1_reg;
    logic            pop;

    assign pop    = (cnt_reg != 2'd0) && tokens.ready;
    assign q_free = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && tokens.ready);

    assign tokens.valid        = cnt_reg != 2'd0;
    assign tokens.token_kind   = slot0_reg.kind;
    assign tokens.token_start  = slot0_reg.start;
    assign tokens.token_length = slot0_reg.length;
    assign tokens.error_kind   = slot0_reg.err;
    assign tokens.last_of_run  = slot0_reg.last;

    always_comb
    begin
        if (step.load && step.count != 2'd0)
        begin
            cnt_next = step.count;
        end
        else
        begin
            cnt_next = cnt_reg - {1'b0, pop};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.load && step.count != 2'd0)
        begin
            slot0_reg <= step.first;
            slot1_reg <= step.second;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("token queue count out of range");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        step.load && step.count != 2'd0 |-> q_free)
        else $error("token queue loaded while holding undelivered tokens");
    a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd1 |-> slot0_reg.last)
        else $error("final token of a step lacks its last mark");
    a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !slot0_reg.last && slot1_reg.last)
        else $error("token pair carries wrong last marks");
`endif

endmodule

`default_nettype wire

// ===== rtl/expression_language_lexer.sv =====
// ----------------------------------------------------------------------------
// Expression language lexer
// Streaming tokenizer: one text byte or end-of-text mark per beat in, tokens
// with kind, start offset, length and error code out.
// ----------------------------------------------------------------------------
// A text beat is registered, then scanned once the result queue has room; the
// tokens it yields are registered in the result queue before they are offered.
// Throughput: one text beat per cycle while each beat yields at most one token
// and tokens are taken; a beat that yields two tokens stalls the beats behind it.
// Reset: asynchronous; clears the scan state, token counters and byte position.
`default_nettype none

module expression_language_lexer #(
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    ell_text_if.sink    text,
    ell_token_if.source tokens
);

    ell_pkg::step_t step;
    logic           q_free;
    logic           in_ready;

    assign text.ready = in_ready;

    ell_core #(
        .PB (POSITION_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text.valid),
        .in_byte  (text.text_byte),
        .in_eot   (text.end_of_text),
        .in_ready (in_ready),
        .q_free   (q_free),
        .step     (step)
    );

    ell_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .q_free (q_free),
        .tokens (tokens)
    );

endmodule

`default_nettype wire
